@@ design/sitda_pkg.sv @@
package sitda_pkg;

   localparam int ValueWidth = 32;
   localparam int DigitWidth = 4;
   localparam int DigitCount = 10;
   localparam int BcdWidth = DigitWidth * DigitCount;
   localparam int StepWidth = $clog2(ValueWidth);
   localparam int CountWidth = $clog2(DigitCount + 1);
   localparam int QueueDepth = 2;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCountWidth = $clog2(QueueDepth + 1);

   localparam logic [7:0] CharMinus = 8'h2D;
   localparam logic [7:0] CharZero = 8'h30;

   typedef struct packed {
      logic                  neg;
      logic [ValueWidth-1:0] mag;
   } work_type;

endpackage

@@ design/sitda_front.sv @@
module sitda_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [sitda_pkg::ValueWidth-1:0] req_value,
   output logic                                work_valid,
   output sitda_pkg::work_type                 work_item,
   input  logic                                work_take
);

   sitda_pkg::work_type queue_ff [sitda_pkg::QueueDepth];
   logic [sitda_pkg::QueuePtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [sitda_pkg::QueuePtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [sitda_pkg::QueueCountWidth-1:0] count_ff, count_in;
   logic                                  push;
   logic                                  pop;
   sitda_pkg::work_type                   classified;

   assign busy = (count_ff == sitda_pkg::QueueCountWidth'(sitda_pkg::QueueDepth));
   assign push = start && !busy;
   assign pop = work_take && work_valid;
   assign work_valid = (count_ff != '0);
   assign work_item = queue_ff[rd_ptr_ff];

   always_comb begin
      classified.neg = req_value[sitda_pkg::ValueWidth-1];
      classified.mag = classified.neg ? (sitda_pkg::ValueWidth'(0) - req_value)
                                      : req_value;
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

@@ design/sitda_back.sv @@
module sitda_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                work_valid,
   input  sitda_pkg::work_type work_item,
   output logic                work_take,
   output logic                rsp_strobe,
   output logic [7:0]          rsp_character,
   output logic                rsp_last
);

   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StConvert = 3'd1;
   localparam logic [2:0] StLocate = 3'd2;
   localparam logic [2:0] StSign = 3'd3;
   localparam logic [2:0] StDigits = 3'd4;

   localparam logic [sitda_pkg::StepWidth-1:0] StepLast =
      sitda_pkg::StepWidth'(sitda_pkg::ValueWidth - 1);

   logic [2:0]                            state_ff, state_in;
   logic [sitda_pkg::ValueWidth-1:0]      bin_ff, bin_in;
   logic [sitda_pkg::BcdWidth-1:0]        bcd_ff, bcd_in;
   logic [sitda_pkg::BcdWidth-1:0]        bcd_adj;
   logic [sitda_pkg::StepWidth-1:0]       step_ff, step_in;
   logic [sitda_pkg::CountWidth-1:0]      rem_ff, rem_in;
   logic                                  neg_ff, neg_in;
   logic [sitda_pkg::CountWidth-1:0]      digit_idx;
   logic [sitda_pkg::DigitWidth-1:0]      digit;
   logic                                  strobe_ff, strobe_in;
   logic [7:0]                            char_ff, char_in;
   logic                                  last_ff, last_in;

   function automatic logic [sitda_pkg::CountWidth-1:0] digit_total(
      input logic [sitda_pkg::BcdWidth-1:0] bcd
   );
      logic [sitda_pkg::CountWidth-1:0] n;
      n = sitda_pkg::CountWidth'(1);
      for (int i = 1; i < sitda_pkg::DigitCount; i++) begin
         if (bcd[i*sitda_pkg::DigitWidth +: sitda_pkg::DigitWidth] != '0) begin
            n = sitda_pkg::CountWidth'(i + 1);
         end
      end
      return n;
   endfunction

   always_comb begin
      for (int i = 0; i < sitda_pkg::DigitCount; i++) begin
         if (bcd_ff[i*sitda_pkg::DigitWidth +: sitda_pkg::DigitWidth] >= 4'd5) begin
            bcd_adj[i*sitda_pkg::DigitWidth +: sitda_pkg::DigitWidth] =
               bcd_ff[i*sitda_pkg::DigitWidth +: sitda_pkg::DigitWidth] + 4'd3;
         end else begin
            bcd_adj[i*sitda_pkg::DigitWidth +: sitda_pkg::DigitWidth] =
               bcd_ff[i*sitda_pkg::DigitWidth +: sitda_pkg::DigitWidth];
         end
      end
   end

   assign digit_idx = rem_ff - 1'b1;
   assign digit = bcd_ff[{digit_idx, 2'b00} +: sitda_pkg::DigitWidth];
   assign work_take = (state_ff == StIdle) && work_valid;

   always_comb begin
      state_in = state_ff;
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      step_in = step_ff;
      rem_in = rem_ff;
      neg_in = neg_ff;
      strobe_in = 1'b0;
      char_in = char_ff;
      last_in = 1'b0;
      unique case (state_ff)
         StIdle: begin
            if (work_valid) begin
               bin_in = work_item.mag;
               neg_in = work_item.neg;
               bcd_in = '0;
               step_in = '0;
               state_in = StConvert;
            end
         end
         StConvert: begin
            bcd_in = {bcd_adj[sitda_pkg::BcdWidth-2:0], bin_ff[sitda_pkg::ValueWidth-1]};
            bin_in = {bin_ff[sitda_pkg::ValueWidth-2:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == StepLast) begin
               state_in = StLocate;
            end
         end
         StLocate: begin
            rem_in = digit_total(bcd_ff);
            state_in = neg_ff ? StSign : StDigits;
         end
         StSign: begin
            strobe_in = 1'b1;
            char_in = sitda_pkg::CharMinus;
            state_in = StDigits;
         end
         StDigits: begin
            strobe_in = 1'b1;
            char_in = sitda_pkg::CharZero + {4'b0000, digit};
            last_in = (rem_ff == sitda_pkg::CountWidth'(1));
            rem_in = rem_ff - 1'b1;
            if (rem_ff == sitda_pkg::CountWidth'(1)) begin
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      step_ff <= step_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_character = char_ff;
   assign rsp_last = last_ff;

endmodule

@@ design/signed_int_to_decimal_ascii.sv @@
// The first character appears after a value is converted and its digits are counted.
// The single conversion unit runs 32 shift-add-3 steps, a digit count step, the minus
// sign if negative, one character out per cycle; it takes a new value only once idle.
// A two-entry queue takes values while a conversion runs; busy is high when it is full.
// Synchronous active-high reset empties the queue and returns the converter to idle.
// The receiver cannot stall, so each character is shown for exactly one cycle.
module signed_int_to_decimal_ascii (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic signed [sitda_pkg::ValueWidth-1:0] req_value,
   output logic                                    rsp_strobe,
   output logic [7:0]                              rsp_character,
   output logic                                    rsp_last
);

   logic                work_valid;
   logic                work_take;
   sitda_pkg::work_type work_item;

   sitda_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_value  (req_value),
      .work_valid (work_valid),
      .work_item  (work_item),
      .work_take  (work_take)
   );

   sitda_back u_back (
      .clock         (clock),
      .reset         (reset),
      .work_valid    (work_valid),
      .work_item     (work_item),
      .work_take     (work_take),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

@@ design/sitda_checker.sv @@
module sitda_checker (
   input logic       clock,
   input logic       reset,
   input logic       busy,
   input logic       rsp_strobe,
   input logic [7:0] rsp_character,
   input logic       rsp_last
);

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !busy && !rsp_strobe)
      else $error("outputs not quiet after reset");

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_character == sitda_pkg::CharMinus) ||
                     (rsp_character >= sitda_pkg::CharZero &&
                      rsp_character <= sitda_pkg::CharZero + 8'd9))
      else $error("character outside the decimal set");

   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe)
      else $error("gap inside a character run");

   a_sign_then_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_character == sitda_pkg::CharMinus |->
         !rsp_last ##1 (rsp_character != sitda_pkg::CharMinus))
      else $error("minus sign not followed by a digit");

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (
   .clock         (clock),
   .reset         (reset),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_character (rsp_character),
   .rsp_last      (rsp_last)
);

@@ test/testbench.sv @@
module testbench;

   localparam int StallLimit = 2000;

   typedef struct {
      logic [7:0] character;
      logic       last;
   } text_char_type;

   class text_scoreboard;
      text_char_type pending_chars[$];
      int mismatches;
      int values_seen;
      int negatives_seen;
      int chars_checked;

      function new();
         mismatches = 0;
         values_seen = 0;
         negatives_seen = 0;
         chars_checked = 0;
      endfunction

      // Spells the accepted value in decimal and queues the characters it should produce.
      function void note_value(logic [sitda_pkg::ValueWidth-1:0] value);
         logic [sitda_pkg::ValueWidth-1:0] mag;
         logic [3:0] digits[sitda_pkg::DigitCount];
         int count;
         text_char_type entry;
         values_seen++;
         mag = value[sitda_pkg::ValueWidth-1] ? -value : value;
         count = 0;
         do begin
            digits[count] = 4'(mag % 10);
            mag = mag / 10;
            count++;
         end while (mag != 0 && count < sitda_pkg::DigitCount);
         if (value[sitda_pkg::ValueWidth-1]) begin
            negatives_seen++;
            entry.character = sitda_pkg::CharMinus;
            entry.last = 1'b0;
            pending_chars.push_back(entry);
         end
         for (int i = count - 1; i >= 0; i--) begin
            entry.character = sitda_pkg::CharZero + digits[i];
            entry.last = (i == 0);
            pending_chars.push_back(entry);
         end
      endfunction

      function void check_char(logic [7:0] character, logic last);
         text_char_type want;
         if (pending_chars.size() == 0) begin
            $display("%0t: expected no character, actual character %h last %b",
                     $time, character, last);
            mismatches++;
            return;
         end
         want = pending_chars.pop_front();
         chars_checked++;
         if (want.character !== character) begin
            $display("%0t: character expected %h actual %h",
                     $time, want.character, character);
            mismatches++;
         end
         if (want.last !== last) begin
            $display("%0t: last flag expected %b actual %b", $time, want.last, last);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic signed [sitda_pkg::ValueWidth-1:0] req_value;
   logic rsp_strobe;
   logic [7:0] rsp_character;
   logic rsp_last;

   text_scoreboard sb = new();
   int idle_percent;
   int stall_cycles = 0;
   int phase_idle[3] = '{0, 62, 28};
   int directed_values[] = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345, -67890,
                             999999999, -999999999, 1000000000, -1000000000, 1234567890,
                             2147483647, -2147483647, 32'h80000000, 1999999999};

   signed_int_to_decimal_ascii dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_value(req_value),
      .rsp_strobe(rsp_strobe),
      .rsp_character(rsp_character),
      .rsp_last(rsp_last)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            sb.note_value(req_value);
         end
         if (rsp_strobe) begin
            sb.check_char(rsp_character, rsp_last);
         end
         if ((start && !busy) || rsp_strobe) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= StallLimit) begin
            $display("%0t: no transfer for %0d cycles", $time, StallLimit);
            $display("signed_int_to_decimal_ascii verification failed");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   function automatic logic [sitda_pkg::ValueWidth-1:0] random_value();
      longint bound;
      logic [sitda_pkg::ValueWidth-1:0] mag;
      int width;
      case ($urandom_range(0, 3))
         0: begin
            return $urandom;
         end
         1: begin
            if ($urandom_range(0, 1))
               return 32'h80000000 + $urandom_range(0, 20);
            return 32'h7FFFFFFF - $urandom_range(0, 20);
         end
         default: begin
            width = $urandom_range(1, 10);
            bound = 1;
            repeat (width) bound = bound * 10;
            if (bound > 64'd2147483648) bound = 64'd2147483648;
            mag = $urandom_range(0, bound - 1);
            return $urandom_range(0, 1) ? -mag : mag;
         end
      endcase
   endfunction

   task automatic send_value(input logic [sitda_pkg::ValueWidth-1:0] value);
      int gap;
      gap = 0;
      if (idle_percent > 0) begin
         if ($urandom_range(0, 99) < 3) begin
            gap = $urandom_range(1, 60);
         end else begin
            while ($urandom_range(0, 99) < idle_percent && gap < 40) gap++;
         end
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) begin
            req_value <= $urandom;
            @(posedge clock);
         end
      end
      start <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (busy);
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_value = '0;
      idle_percent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_values[i]) send_value(directed_values[i]);
      foreach (phase_idle[p]) begin
         idle_percent = phase_idle[p];
         repeat (170) send_value(random_value());
      end
      start <= 1'b0;

      @(posedge clock);
      while (sb.pending_chars.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Converted %0d values, %0d of them negative, and checked %0d characters",
               sb.values_seen, sb.negatives_seen, sb.chars_checked);
      $display("under sender idle rates of 0, 62 and 28 percent.");
      if (sb.mismatches == 0 && sb.pending_chars.size() == 0) begin
         $display("signed_int_to_decimal_ascii verification clean");
      end else begin
         if (sb.pending_chars.size() != 0)
            $display("%0t: %0d expected characters never arrived",
                     $time, sb.pending_chars.size());
         $display("signed_int_to_decimal_ascii verification failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/sitda_pkg.sv
design/sitda_front.sv
design/sitda_back.sv
design/signed_int_to_decimal_ascii.sv
design/sitda_checker.sv
test/testbench.sv
